### rtl/dtfp_pkg.sv
// decimal text to fixed point: shared constants, character codes and types
// no dependencies; used by every module of the block
package dtfp_pkg;

  localparam int unsigned FractionDigitsDef = 3;
  localparam int unsigned FractionDigitsMax = 6;

  localparam logic [31:0] MagMax = 32'h7fff_ffff;
  localparam int unsigned IntW   = 31;

  localparam logic [7:0] CharMinus = 8'h2d;
  localparam logic [7:0] CharDot   = 8'h2e;
  localparam logic [7:0] CharZero  = 8'h30;
  localparam logic [7:0] CharNine  = 8'h39;

  typedef struct packed {
    logic neg;
    logic sat;
  } dtfp_flags_t;

  function automatic longint unsigned pow10(input int unsigned n);
    longint unsigned p;
    p = 64'd1;
    for (int unsigned i = 0; i < FractionDigitsMax; i++) begin
      if (i < n) begin
        p = p * 64'd10;
      end
    end
    return p;
  endfunction

endpackage

### rtl/dtfp_accum.sv
// character stage: input register, sign/dot/digit parsing and accumulators
// closes a string on last into a snapshot register; uses dtfp_pkg
module dtfp_accum #(
  parameter int unsigned FractionDigits = dtfp_pkg::FractionDigitsDef,
  parameter int unsigned FracW          = $clog2(dtfp_pkg::pow10(FractionDigits))
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      adv_i,
  input  logic                      in_valid_i,
  input  logic [7:0]                char_code_i,
  input  logic                      last_i,
  output logic                      snap_valid_o,
  output logic [dtfp_pkg::IntW-1:0] snap_int_o,
  output logic [FracW-1:0]          snap_frac_o,
  output dtfp_pkg::dtfp_flags_t     snap_flags_o
);
  import dtfp_pkg::*;

  localparam int unsigned CntW = $clog2(FractionDigits + 1);

  logic             in_valid_q;
  logic [7:0]       char_q;
  logic             last_q;

  logic             first_q, first_d;
  logic             neg_q, neg_d, neg_u;
  logic             frac_on_q, frac_on_d, frac_on_u;
  logic             stop_q, stop_d, stop_u;
  logic [IntW-1:0]  int_q, int_d, int_u;
  logic [FracW-1:0] frac_q, frac_d, frac_u;
  logic [CntW-1:0]  cnt_q, cnt_d, cnt_u;
  logic             sat_q, sat_d, sat_u;

  logic [3:0]       digit;
  logic             is_digit;
  logic [IntW+3:0]  int_sum;
  logic [FracW-1:0] place;

  logic             snap_valid_q;
  logic [IntW-1:0]  snap_int_q;
  logic [FracW-1:0] snap_frac_q;
  dtfp_flags_t      snap_flags_q;

  assign digit    = char_q[3:0];
  assign is_digit = (char_q >= CharZero) && (char_q <= CharNine);
  assign int_sum  = {int_q, 3'b000} + {2'b00, int_q, 1'b0} + (IntW+4)'(digit);

  // weight of the next fraction digit
  always_comb begin
    place = '0;
    for (int unsigned i = 0; i < FractionDigits; i++) begin
      if (cnt_q == CntW'(i)) begin
        place = FracW'(pow10(FractionDigits - 1 - i));
      end
    end
  end

  always_comb begin
    neg_u     = neg_q;
    frac_on_u = frac_on_q;
    stop_u    = stop_q;
    int_u     = int_q;
    frac_u    = frac_q;
    cnt_u     = cnt_q;
    sat_u     = sat_q;
    if (!stop_q) begin
      if (first_q && char_q == CharMinus) begin
        neg_u = 1'b1;
      end else if (char_q == CharDot) begin
        frac_on_u = 1'b1;
      end else if (is_digit) begin
        if (frac_on_q) begin
          if (cnt_q < CntW'(FractionDigits)) begin
            frac_u = frac_q + FracW'(digit * place);
            cnt_u  = cnt_q + CntW'(1);
          end
        end else if (int_sum > (IntW+4)'(MagMax)) begin
          int_u = MagMax[IntW-1:0];
          sat_u = 1'b1;
        end else begin
          int_u = int_sum[IntW-1:0];
        end
      end else begin
        stop_u = 1'b1;
      end
    end

    first_d   = first_q;
    neg_d     = neg_q;
    frac_on_d = frac_on_q;
    stop_d    = stop_q;
    int_d     = int_q;
    frac_d    = frac_q;
    cnt_d     = cnt_q;
    sat_d     = sat_q;
    if (in_valid_q) begin
      if (last_q) begin
        first_d   = 1'b1;
        neg_d     = 1'b0;
        frac_on_d = 1'b0;
        stop_d    = 1'b0;
        int_d     = '0;
        frac_d    = '0;
        cnt_d     = '0;
        sat_d     = 1'b0;
      end else begin
        first_d   = 1'b0;
        neg_d     = neg_u;
        frac_on_d = frac_on_u;
        stop_d    = stop_u;
        int_d     = int_u;
        frac_d    = frac_u;
        cnt_d     = cnt_u;
        sat_d     = sat_u;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q   <= 1'b0;
      snap_valid_q <= 1'b0;
      first_q      <= 1'b1;
      neg_q        <= 1'b0;
      frac_on_q    <= 1'b0;
      stop_q       <= 1'b0;
      int_q        <= '0;
      frac_q       <= '0;
      cnt_q        <= '0;
      sat_q        <= 1'b0;
    end else if (adv_i) begin
      in_valid_q   <= in_valid_i;
      snap_valid_q <= in_valid_q && last_q;
      first_q      <= first_d;
      neg_q        <= neg_d;
      frac_on_q    <= frac_on_d;
      stop_q       <= stop_d;
      int_q        <= int_d;
      frac_q       <= frac_d;
      cnt_q        <= cnt_d;
      sat_q        <= sat_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      char_q           <= char_code_i;
      last_q           <= last_i;
      snap_int_q       <= int_u;
      snap_frac_q      <= frac_u;
      snap_flags_q.neg <= neg_u;
      snap_flags_q.sat <= sat_u;
    end
  end

  assign snap_valid_o = snap_valid_q;
  assign snap_int_o   = snap_int_q;
  assign snap_frac_o  = snap_frac_q;
  assign snap_flags_o = snap_flags_q;

endmodule

### rtl/dtfp_scale.sv
// result stages: integer part times the scale plus fraction, then clamp,
// sign and output register; uses dtfp_pkg
module dtfp_scale #(
  parameter int unsigned FractionDigits = dtfp_pkg::FractionDigitsDef,
  parameter int unsigned FracW          = $clog2(dtfp_pkg::pow10(FractionDigits))
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      adv_i,
  input  logic                      snap_valid_i,
  input  logic [dtfp_pkg::IntW-1:0] snap_int_i,
  input  logic [FracW-1:0]          snap_frac_i,
  input  dtfp_pkg::dtfp_flags_t     snap_flags_i,
  output logic                      out_valid_o,
  output logic [31:0]               value_o,
  output logic                      overflow_o
);
  import dtfp_pkg::*;

  localparam int unsigned ScaleW = $clog2(pow10(FractionDigits) + 1);
  localparam int unsigned MagW   = IntW + ScaleW + 1;
  localparam logic [ScaleW-1:0] Scale = ScaleW'(pow10(FractionDigits));

  logic            mag_valid_q;
  logic [MagW-1:0] mag_q, mag_d;
  dtfp_flags_t     mag_flags_q;

  logic            out_valid_q;
  logic [31:0]     value_q, value_d;
  logic            ovf_q, ovf_d;
  logic [31:0]     clamped;

  assign mag_d = MagW'(snap_int_i) * MagW'(Scale) + MagW'(snap_frac_i);

  always_comb begin
    ovf_d   = mag_flags_q.sat;
    clamped = mag_q[31:0];
    if (mag_q > MagW'(MagMax)) begin
      clamped = MagMax;
      ovf_d   = 1'b1;
    end
    value_d = mag_flags_q.neg ? (32'd0 - clamped) : clamped;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mag_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (adv_i) begin
      mag_valid_q <= snap_valid_i;
      out_valid_q <= mag_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      mag_q       <= mag_d;
      mag_flags_q <= snap_flags_i;
      value_q     <= value_d;
      ovf_q       <= ovf_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign value_o     = value_q;
  assign overflow_o  = ovf_q;

endmodule

### rtl/decimal_text_to_fixed_point.sv
// decimal text to fixed point: top level, stream ports and stage control
// instantiates dtfp_accum and dtfp_scale; uses dtfp_pkg
//
// usage:
//   the slave stream takes one ascii character per word in s_axis_tdata_i,
//   with s_axis_tlast_i on the final character of a number string
//   on the word marked last the master stream gives one word: the number
//   times 10^FractionDigits as a signed 32-bit value in m_axis_tdata_o and
//   the saturation flag in m_axis_tuser_o; other words give no output
//   a leading '-' sets the sign, '.' starts the fraction, any other
//   non-digit ends parsing until the end of the string
//   throughput: one character per cycle; the pipeline is four registers
//   (input, accumulator snapshot, scaled magnitude, output) moving together
//   when the receiver stalls the whole pipeline holds and s_axis_tready_o
//   drops until the output word is taken
//   reset clears all valid bits and the parse state, ready for a new string
module decimal_text_to_fixed_point #(
  parameter int unsigned FractionDigits = dtfp_pkg::FractionDigitsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] char_code
  input  logic        s_axis_tlast_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [31:0] m_axis_tdata_o,   // [31:0] value
  output logic        m_axis_tuser_o    // [0] overflow
);
  import dtfp_pkg::*;

  localparam int unsigned FracW = $clog2(pow10(FractionDigits));

  logic             adv;
  logic             snap_valid;
  logic [IntW-1:0]  snap_int;
  logic [FracW-1:0] snap_frac;
  dtfp_flags_t      snap_flags;

  assign adv             = !m_axis_tvalid_o || m_axis_tready_i;
  assign s_axis_tready_o = adv;

  dtfp_accum #(
    .FractionDigits(FractionDigits),
    .FracW         (FracW)
  ) u_accum (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .adv_i       (adv),
    .in_valid_i  (s_axis_tvalid_i),
    .char_code_i (s_axis_tdata_i),
    .last_i      (s_axis_tlast_i),
    .snap_valid_o(snap_valid),
    .snap_int_o  (snap_int),
    .snap_frac_o (snap_frac),
    .snap_flags_o(snap_flags)
  );

  dtfp_scale #(
    .FractionDigits(FractionDigits),
    .FracW         (FracW)
  ) u_scale (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .adv_i       (adv),
    .snap_valid_i(snap_valid),
    .snap_int_i  (snap_int),
    .snap_frac_i (snap_frac),
    .snap_flags_i(snap_flags),
    .out_valid_o (m_axis_tvalid_o),
    .value_o     (m_axis_tdata_o),
    .overflow_o  (m_axis_tuser_o)
  );

  // input side only stalls behind a waiting output word
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> m_axis_tvalid_o)
    else $error("input stalled without a pending output word");

  // saturated range is symmetric, the most negative code never appears
  a_no_min_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> m_axis_tdata_o != 32'h8000_0000)
    else $error("result holds the most negative code");

  // a positive overflowed result sits exactly at the clamp
  a_ovf_clamp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tuser_o && !m_axis_tdata_o[31])
      |-> m_axis_tdata_o == MagMax)
    else $error("overflow flag without clamped value");

endmodule
